FILE: src/wsc_pkg.sv
// Package with shared types, widths and codes for the workload statistics classifier.
`timescale 1ns / 1ps
`default_nettype none
package wsc_pkg;
	localparam int MaxProcesses = 4096;
	localparam int CntW         = 13;
	localparam int TickBits     = 24;
	localparam int BurstW       = 25;
	localparam int DivW         = 70;
	localparam int ValW         = 63;
	localparam int StatCount    = 17;

	// Stat identifiers.
	localparam logic [4:0] STAT_CLASS    = 5'd0;
	localparam logic [4:0] STAT_AVG_CPU  = 5'd10;
	localparam logic [4:0] STAT_AVG_PRI  = 5'd11;
	localparam logic [4:0] STAT_AVG_NICE = 5'd12;
	localparam logic [4:0] STAT_AVG_BUR  = 5'd13;
	localparam logic [4:0] STAT_MIN      = 5'd14;
	localparam logic [4:0] STAT_MAX      = 5'd15;
	localparam logic [4:0] STAT_VAR      = 5'd16;

	// Configuration register indexes.
	localparam logic [2:0] REG_LIGHT   = 3'd0;
	localparam logic [2:0] REG_MEDIUM  = 3'd1;
	localparam logic [2:0] REG_SYSCPU  = 3'd2;
	localparam logic [2:0] REG_CPUB    = 3'd3;
	localparam logic [2:0] REG_IOB     = 3'd4;
	localparam logic [2:0] REG_SMALLB  = 3'd5;
	localparam logic [2:0] REG_MEDB    = 3'd6;

	// Workload classes.
	localparam logic [2:0] CLS_LIGHT  = 3'd0;
	localparam logic [2:0] CLS_MEDIUM = 3'd1;
	localparam logic [2:0] CLS_HEAVY  = 3'd2;
	localparam logic [2:0] CLS_CPU    = 3'd3;
	localparam logic [2:0] CLS_IO     = 3'd4;
	localparam logic [2:0] CLS_MIXED  = 3'd5;
	localparam logic [2:0] CLS_INTER  = 3'd6;

	// Request to the shared divider.
	typedef struct packed {
		logic            start;
		logic [DivW-1:0] dividend;
		logic [CntW-1:0] divisor;
	} div_req_t;

	// Answer from the shared divider.
	typedef struct packed {
		logic            done;
		logic [DivW-1:0] quot;
		logic [CntW-1:0] rem;
	} div_rsp_t;
endpackage
`default_nettype wire

FILE: src/wsc_divider.sv
// Restoring divider, one quotient bit per cycle, shared by the averages and the variance.
`timescale 1ns / 1ps
`default_nettype none
module wsc_divider
	import wsc_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);
	logic            busy_q;
	logic            done_q;
	logic [6:0]      step_q;
	logic [DivW-1:0] quot_q;
	logic [CntW-1:0] rem_q;
	logic [CntW-1:0] dsr_q;
	logic [CntW:0]   trial;

	// Shift in the next dividend bit and try a subtract.
	assign trial = {rem_q, quot_q[DivW-1]};

	// Control state of the iteration; the answer is flagged once the last bit has landed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= 7'(DivW - 1);
		end else if (busy_q) begin
			if (step_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				step_q <= step_q - 7'd1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Datapath of the iteration.
	always_ff @(posedge clk) begin
		if (req.start) begin
			quot_q <= req.dividend;
			rem_q  <= '0;
			dsr_q  <= req.divisor;
		end else if (busy_q) begin
			if (trial >= {1'b0, dsr_q}) begin
				rem_q  <= CntW'(trial - {1'b0, dsr_q});
				quot_q <= {quot_q[DivW-2:0], 1'b1};
			end else begin
				rem_q  <= trial[CntW-1:0];
				quot_q <= {quot_q[DivW-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;
	assign rsp.rem  = rem_q;
endmodule
`default_nettype wire

FILE: src/workload_stats_classifier.sv
// Top level of the workload statistics classifier: accumulation, sequencer and output.
`timescale 1ns / 1ps
`default_nettype none
//  channel | signals                                         | direction
//  input   | in_valid, in_stall, has_process .. last_process | in, stall out
//  output  | out_valid, out_stall, stat_id, stat_value, last_stat | out, stall in
//  config  | cfg_we, cfg_index, cfg_data                     | in
// A record passes through capture, burst square and absorb; an idle item is taken in capture alone.
// The last item adds a classify step, then up to six divisions through one bit-serial
// divider (each an issue, 70 quotient bits and a hand-back) and two multiply steps, both
// skipped for an empty set, then streams 17 results, one per accepted cycle.
// Reset clears all accumulators and sets the limits to their defaults; no clearing pass.
// in_stall is high whenever the block is not idle; out_stall only holds the result.
module workload_stats_classifier
	import wsc_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [2:0]          cfg_index,
	input  wire logic [24:0]         cfg_data,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic                has_process,
	input  wire logic [19:0]         cpu_usage,
	input  wire logic [7:0]          proc_state,
	input  wire logic signed [8:0]   priority_req,
	input  wire logic signed [5:0]   nice_level,
	input  wire logic [23:0]         user_ticks,
	input  wire logic [23:0]         kernel_ticks,
	input  wire logic [19:0]         system_cpu,
	input  wire logic                last_process,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic [4:0]               stat_id,
	output logic [ValW-1:0]          stat_value,
	output logic                     last_stat
);
	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_ABS  = 4'd1;
	localparam logic [3:0] ST_CLS  = 4'd2;
	localparam logic [3:0] ST_DIVS = 4'd3;
	localparam logic [3:0] ST_DIVW = 4'd4;
	localparam logic [3:0] ST_M1   = 4'd5;
	localparam logic [3:0] ST_M2   = 4'd6;
	localparam logic [3:0] ST_EMIT = 4'd7;
	localparam logic [3:0] ST_SQ   = 4'd8;

	logic [3:0] state_q;
	logic [12:0] light_q, medium_q;
	logic [19:0] syscpu_lim_q, cpub_q, iob_q;
	logic [24:0] smallb_q, medb_q;

	// Captured input item.
	logic        has_q, last_q;
	logic [19:0] cpu_q, sysc_q;
	logic [7:0]  st_q;
	logic [8:0]  pabs_q;
	logic [5:0]  nabs_q;
	logic [24:0] burst_q;

	// Accumulators.
	logic [CntW-1:0] total_q, bcount_q;
	logic [CntW-1:0] cnt_q [8];
	logic [31:0]     cpu_sum_q;
	logic [20:0]     pri_sum_q;
	logic [17:0]     nice_sum_q;
	logic [36:0]     bsum_q;
	logic [61:0]     bsq_q;
	logic [24:0]     bmin_q, bmax_q;

	// Final results; the averages hold cpu, priority, nice and burst in that order.
	logic [2:0]      cls_q;
	logic [ValW-1:0] v_q [4];
	logic [2:0]      div_k_q;
	logic [4:0]      emit_q;
	logic [57:0]     sq8_q;
	logic [57:0]     m2_q;
	logic [49:0]     aa_q;
	logic [32:0]     af_q;

	div_req_t dreq;
	div_rsp_t drsp;

	wsc_divider u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	logic in_acc, out_acc;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = (state_q == ST_EMIT);
	assign out_acc   = out_valid && !out_stall;

	// Square of the captured burst, one multiply in its own cycle.
	logic [49:0] bsq_add;
	assign bsq_add = 50'(burst_q) * 50'(burst_q);

	// Divider operand selection by division step.
	logic [DivW-1:0] dvd;
	logic [CntW-1:0] dsr;
	always_comb begin
		dvd = '0;
		dsr = total_q;
		case (div_k_q)
			3'd0: dvd = DivW'(cpu_sum_q);
			3'd1: dvd = DivW'({pri_sum_q, 8'd0});
			3'd2: dvd = DivW'({nice_sum_q, 8'd0});
			3'd3: begin dvd = DivW'({bsum_q, 8'd0}); dsr = bcount_q; end
			3'd4: begin dvd = DivW'(bsq_q); dsr = bcount_q; end
			3'd5: begin dvd = DivW'({drsp.rem, 8'd0}); dsr = bcount_q; end
			default: dvd = '0;
		endcase
	end
	assign dreq.start    = (state_q == ST_DIVS);
	assign dreq.dividend = dvd;
	assign dreq.divisor  = dsr;

	logic [CntW-1:0] cnt_inc [8];
	logic [7:0]      hit;
	always_comb begin
		hit[0] = (st_q == 8'h52) || (st_q == 8'h72);
		hit[1] = (st_q == 8'h53) || (st_q == 8'h73);
		hit[2] = cpu_q > cpub_q;
		hit[3] = !hit[2] && (cpu_q < iob_q);
		hit[4] = !hit[2] && !hit[3] && (cpu_q != '0);
		hit[5] = burst_q < smallb_q;
		hit[6] = !hit[5] && (burst_q < medb_q);
		hit[7] = !hit[5] && !hit[6];
		for (int k = 0; k < 8; k++) cnt_inc[k] = cnt_q[k] + CntW'(hit[k]);
	end

	// Saturating sums.
	logic [49:0] sq_s1;
	logic [32:0] cs_n;
	logic [21:0] ps_n;
	logic [18:0] ns_n;
	logic [37:0] bs_n;
	logic [62:0] qs_n;
	assign cs_n = {1'b0, cpu_sum_q} + 33'(cpu_q);
	assign ps_n = {1'b0, pri_sum_q} + 22'(pabs_q);
	assign ns_n = {1'b0, nice_sum_q} + 19'(nabs_q);
	assign bs_n = {1'b0, bsum_q} + 38'(burst_q);
	assign qs_n = {1'b0, bsq_q} + 63'(sq_s1);

	// Classification of the whole set.
	logic [2:0] cls_n;
	always_comb begin
		if (total_q < light_q) cls_n = CLS_LIGHT;
		else if (total_q < medium_q) cls_n = CLS_MEDIUM;
		else cls_n = CLS_HEAVY;
		if (sysc_q > syscpu_lim_q) cls_n = CLS_CPU;
		else if ({cnt_q[3], 1'b0} > {1'b0, total_q}) cls_n = CLS_IO;
		else if (16'(cnt_q[4]) * 16'd5 > {2'b0, total_q, 1'b0}) cls_n = CLS_INTER;
		else if (cnt_q[0] != '0 && cnt_q[1] != '0) cls_n = CLS_MIXED;
		if (total_q == '0) cls_n = CLS_LIGHT;
	end

	logic [32:0] mq_w;
	logic [24:0] a_w;
	logic [7:0]  f_w;
	assign mq_w = v_q[3][32:0];
	assign a_w  = mq_w[32:8];
	assign f_w  = mq_w[7:0];

	// Sequencer and datapath.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			light_q      <= 13'd20;
			medium_q     <= 13'd100;
			syscpu_lim_q <= 20'd17920;
			cpub_q       <= 20'd12800;
			iob_q        <= 20'd1280;
			smallb_q     <= 25'd5;
			medb_q       <= 25'd50;
			total_q      <= '0;
			bcount_q     <= '0;
			for (int k = 0; k < 8; k++) cnt_q[k] <= '0;
			cpu_sum_q    <= '0;
			pri_sum_q    <= '0;
			nice_sum_q   <= '0;
			bsum_q       <= '0;
			bsq_q        <= '0;
			bmin_q       <= '1;
			bmax_q       <= '0;
			emit_q       <= '0;
			div_k_q      <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_LIGHT:  light_q      <= cfg_data[12:0];
					REG_MEDIUM: medium_q     <= cfg_data[12:0];
					REG_SYSCPU: syscpu_lim_q <= cfg_data[19:0];
					REG_CPUB:   cpub_q       <= cfg_data[19:0];
					REG_IOB:    iob_q        <= cfg_data[19:0];
					REG_SMALLB: smallb_q     <= cfg_data;
					REG_MEDB:   medb_q       <= cfg_data;
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc && (has_process || last_process)) state_q <= ST_SQ;
				end
				ST_SQ: state_q <= ST_ABS;
				ST_ABS: begin
					if (has_q && (32'(total_q) < MaxProcesses)) begin
						total_q    <= total_q + 13'd1;
						for (int k = 0; k < 8; k++) cnt_q[k] <= cnt_inc[k];
						cpu_sum_q  <= cs_n[32] ? '1 : cs_n[31:0];
						pri_sum_q  <= ps_n[21] ? '1 : ps_n[20:0];
						nice_sum_q <= ns_n[18] ? '1 : ns_n[17:0];
						if (burst_q != '0) begin
							bsum_q   <= bs_n[37] ? '1 : bs_n[36:0];
							bsq_q    <= qs_n[62] ? '1 : qs_n[61:0];
							bcount_q <= bcount_q + 13'd1;
							if (burst_q > bmax_q) bmax_q <= burst_q;
							if (burst_q < bmin_q) bmin_q <= burst_q;
						end
					end
					state_q <= last_q ? ST_CLS : ST_IDLE;
				end
				ST_CLS: begin
					div_k_q <= '0;
					state_q <= (total_q == '0) ? ST_EMIT : ST_DIVS;
				end
				ST_DIVS: state_q <= ST_DIVW;
				ST_DIVW: begin
					if (drsp.done) begin
						if (div_k_q == 3'd5 || (div_k_q == 3'd2 && bcount_q == '0)) begin
							state_q <= ST_M1;
						end else begin
							div_k_q <= div_k_q + 3'd1;
							state_q <= ST_DIVS;
						end
					end
				end
				ST_M1: state_q <= ST_M2;
				ST_M2: state_q <= ST_EMIT;
				ST_EMIT: begin
					if (out_acc) begin
						if (emit_q == 5'(StatCount - 1)) begin
							emit_q     <= '0;
							state_q    <= ST_IDLE;
							total_q    <= '0;
							bcount_q   <= '0;
							for (int k = 0; k < 8; k++) cnt_q[k] <= '0;
							cpu_sum_q  <= '0;
							pri_sum_q  <= '0;
							nice_sum_q <= '0;
							bsum_q     <= '0;
							bsq_q      <= '0;
							bmin_q     <= '1;
							bmax_q     <= '0;
						end else begin
							emit_q <= emit_q + 5'd1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload registers: captured item, quotients and variance terms.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			has_q   <= has_process;
			last_q  <= last_process;
			cpu_q   <= cpu_usage;
			sysc_q  <= system_cpu;
			st_q    <= proc_state;
			pabs_q  <= priority_req[8] ? 9'(-priority_req) : priority_req;
			nabs_q  <= nice_level[5] ? 6'(-nice_level) : nice_level;
			burst_q <= 25'(user_ticks[TickBits-1:0]) + 25'(kernel_ticks[TickBits-1:0]);
		end
		if (state_q == ST_SQ) sq_s1 <= bsq_add;
		if (state_q == ST_CLS) begin
			cls_q <= cls_n;
			for (int k = 0; k < 4; k++) v_q[k] <= '0;
		end
		if (state_q == ST_DIVW && drsp.done) begin
			case (div_k_q)
				3'd0: v_q[0] <= ValW'(drsp.quot);
				3'd1: v_q[1] <= ValW'(drsp.quot);
				3'd2: v_q[2] <= ValW'(drsp.quot);
				3'd3: v_q[3] <= ValW'(drsp.quot);
				3'd4: sq8_q  <= {drsp.quot[49:0], 8'd0};
				3'd5: sq8_q  <= sq8_q + 58'(drsp.quot[7:0]);
				default: ;
			endcase
		end
		// Square of the mean in two multiply steps.
		if (state_q == ST_M1) begin
			aa_q <= 50'(a_w) * 50'(a_w);
			af_q <= 33'(a_w) * 33'(f_w);
		end
		if (state_q == ST_M2) begin
			m2_q <= 58'({aa_q, 8'd0}) + 58'({af_q, 1'b0}) + 58'((16'(f_w) * 16'(f_w)) >> 8);
		end
	end

	// Result selection.
	always_comb begin
		stat_id   = emit_q;
		last_stat = (emit_q == STAT_VAR);
		stat_value = '0;
		if (emit_q == STAT_CLASS) stat_value = ValW'(cls_q);
		else if (emit_q == 5'd1) stat_value = ValW'(total_q);
		else if (emit_q <= 5'd9) stat_value = ValW'(cnt_q[3'(emit_q - 5'd2)]);
		else if (emit_q <= STAT_AVG_BUR) stat_value = v_q[2'(emit_q - STAT_AVG_CPU)];
		else if (total_q != '0 && bcount_q != '0) begin
			if (emit_q == STAT_MIN) stat_value = ValW'(bmin_q);
			else if (emit_q == STAT_MAX) stat_value = ValW'(bmax_q);
			else stat_value = (sq8_q > m2_q) ? ValW'(sq8_q - m2_q) : '0;
		end
	end

	// The input side is closed while results are pending.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input open during emission");
	// The final statistic carries the last mark.
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last_stat) |-> (stat_id == STAT_VAR)) else $error("bad last mark");
	// The count never passes its limit.
	a_cap: assert property (@(posedge clk) disable iff (!arst_n)
		32'(total_q) <= MaxProcesses) else $error("count overflow");
	// Emission index advances only on an accepted transaction.
	a_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> $stable(stat_id)) else $error("index moved");
endmodule
`default_nettype wire
